// File: rtl/oidl_pkg.sv
// Shared types, command and status codes for the ordered ID list.
package oidl_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int ID_BITS_DEF     = 32;

	localparam logic [2:0] CMD_CREATE   = 3'd0;
	localparam logic [2:0] CMD_ACTIVATE = 3'd1;
	localparam logic [2:0] CMD_APPEND   = 3'd2;
	localparam logic [2:0] CMD_INSERT   = 3'd3;
	localparam logic [2:0] CMD_CLOSE    = 3'd4;
	localparam logic [2:0] CMD_REORDER  = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ZERO      = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_DUP       = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;
	localparam logic [2:0] ST_LAST      = 3'd5;
	localparam logic [2:0] ST_FULL      = 3'd6;

	typedef logic [1:0] cell_op_t;

	localparam cell_op_t OP_HOLD  = 2'd0;
	localparam cell_op_t OP_LOAD  = 2'd1;
	localparam cell_op_t OP_LEFT  = 2'd2;
	localparam cell_op_t OP_RIGHT = 2'd3;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] pane_id;
		logic [7:0]  position;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  active_index;
		logic [31:0] active_id;
		logic [4:0]  entry_count;
	} rsp_t;

endpackage

// File: rtl/oidl_cell.sv
// One list slot: holds an ID, compares it, and shifts to or from its neighbors.
module oidl_cell #(
	parameter int KEY_W = 32
) (
	input  logic                clk,
	input  logic                en,
	input  oidl_pkg::cell_op_t  op,
	input  logic [KEY_W-1:0]    cmp_key,
	input  logic [KEY_W-1:0]    load_key,
	input  logic [KEY_W-1:0]    left_val,
	input  logic [KEY_W-1:0]    right_val,
	output logic [KEY_W-1:0]    value,
	output logic                match
);

	logic [KEY_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (en) begin
			case (op)
				oidl_pkg::OP_LOAD:  value_q <= load_key;
				oidl_pkg::OP_LEFT:  value_q <= left_val;
				oidl_pkg::OP_RIGHT: value_q <= right_val;
				default:            value_q <= value_q;
			endcase
		end
	end

	assign value = value_q;
	assign match = (value_q == cmp_key);

endmodule

// File: rtl/oidl_exec.sv
// Command decode: status, next count and cursor, and the shift op of every cell.
module oidl_exec #(
	parameter int MAX_ENTRIES = oidl_pkg::MAX_ENTRIES_DEF,
	parameter int CW          = $clog2(MAX_ENTRIES + 1),
	parameter int PW          = $clog2(MAX_ENTRIES)
) (
	input  logic [2:0]                     command,
	input  logic [7:0]                     position,
	input  logic                           key_zero,
	input  logic [MAX_ENTRIES-1:0]         match,
	input  logic [CW-1:0]                  count,
	input  logic [PW-1:0]                  active,
	output logic [2:0]                     status,
	output logic [CW-1:0]                  count_nxt,
	output logic [PW-1:0]                  active_nxt,
	output oidl_pkg::cell_op_t [MAX_ENTRIES-1:0] ops
);

	localparam int XW = ((CW > 8) ? CW : 8) + 1;

	logic          found;
	logic [PW-1:0] idx;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] ins_x;
	logic [PW-1:0] fin;

	always_comb begin
		found = |match;
		idx   = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (match[i])
				idx = idx | PW'(i);
		end
	end

	assign cnt_x = XW'(count);
	assign pos_x = XW'(position);
	assign ins_x = (command == oidl_pkg::CMD_APPEND) ? cnt_x : pos_x;
	assign fin   = PW'(position);

	always_comb begin
		status     = oidl_pkg::ST_OK;
		count_nxt  = count;
		active_nxt = active;
		for (int i = 0; i < MAX_ENTRIES; i++)
			ops[i] = oidl_pkg::OP_HOLD;
		case (command)
			oidl_pkg::CMD_CREATE: begin
				if (key_zero) begin
					status = oidl_pkg::ST_ZERO;
				end else begin
					ops[0]     = oidl_pkg::OP_LOAD;
					count_nxt  = CW'(1);
					active_nxt = '0;
				end
			end
			oidl_pkg::CMD_ACTIVATE: begin
				if (key_zero)
					status = oidl_pkg::ST_ZERO;
				else if (!found)
					status = oidl_pkg::ST_NOT_FOUND;
				else
					active_nxt = idx;
			end
			oidl_pkg::CMD_APPEND, oidl_pkg::CMD_INSERT: begin
				if (key_zero) begin
					status = oidl_pkg::ST_ZERO;
				end else if (found) begin
					status = oidl_pkg::ST_DUP;
				end else if (ins_x > cnt_x) begin
					status = oidl_pkg::ST_RANGE;
				end else if (count == CW'(MAX_ENTRIES)) begin
					status = oidl_pkg::ST_FULL;
				end else begin
					for (int i = 0; i < MAX_ENTRIES; i++) begin
						if (XW'(i) < ins_x)
							ops[i] = oidl_pkg::OP_HOLD;
						else if (XW'(i) == ins_x)
							ops[i] = oidl_pkg::OP_LOAD;
						else
							ops[i] = oidl_pkg::OP_LEFT;
					end
					count_nxt  = count + CW'(1);
					active_nxt = PW'(ins_x);
				end
			end
			oidl_pkg::CMD_CLOSE: begin
				if (key_zero) begin
					status = oidl_pkg::ST_ZERO;
				end else if (!found) begin
					status = oidl_pkg::ST_NOT_FOUND;
				end else if (count == CW'(1)) begin
					status = oidl_pkg::ST_LAST;
				end else begin
					for (int i = 0; i < MAX_ENTRIES; i++) begin
						if (PW'(i) >= idx)
							ops[i] = oidl_pkg::OP_RIGHT;
					end
					count_nxt = count - CW'(1);
					if (idx == active) begin
						if (CW'(active) > count - CW'(2))
							active_nxt = PW'(count - CW'(2));
					end else if (idx < active) begin
						active_nxt = active - PW'(1);
					end
				end
			end
			oidl_pkg::CMD_REORDER: begin
				if (key_zero) begin
					status = oidl_pkg::ST_ZERO;
				end else if (!found) begin
					status = oidl_pkg::ST_NOT_FOUND;
				end else if (pos_x >= cnt_x) begin
					status = oidl_pkg::ST_RANGE;
				end else begin
					for (int i = 0; i < MAX_ENTRIES; i++) begin
						if (PW'(i) == fin)
							ops[i] = oidl_pkg::OP_LOAD;
						else if (idx < fin && PW'(i) >= idx && PW'(i) < fin)
							ops[i] = oidl_pkg::OP_RIGHT;
						else if (idx > fin && PW'(i) > fin && PW'(i) <= idx)
							ops[i] = oidl_pkg::OP_LEFT;
					end
					if (active == idx)
						active_nxt = fin;
					else if (idx < active && fin >= active)
						active_nxt = active - PW'(1);
					else if (idx > active && fin <= active)
						active_nxt = active + PW'(1);
				end
			end
			default: begin
				status = oidl_pkg::ST_OK;
			end
		endcase
	end

endmodule

// File: rtl/ordered_id_list_with_cursor.sv
// Top level of the ordered ID list with cursor: request stages, cell chain, result register.
//
//   channel  dir  handshake               payload
//   req      in   req_valid / req_ready   oidl_pkg::req_t
//   rsp      out  rsp_valid / rsp_ready   oidl_pkg::rsp_t
//
// A request first passes a stage in which every cell compares its ID with the
// request, then a stage that decodes the command and shifts the cells.
// A new request enters in the cycle its predecessor commits; none is taken
// while one waits in the compare stage. Reset clears count and cursor at once;
// slots are not cleared. While a response is pending and rsp_ready is low,
// the commit stage holds and req_ready stays low until it is taken.
module ordered_id_list_with_cursor #(
	parameter int MAX_ENTRIES = oidl_pkg::MAX_ENTRIES_DEF,
	parameter int ID_BITS     = oidl_pkg::ID_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  oidl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output oidl_pkg::rsp_t rsp
);

	localparam int KEY_W = (ID_BITS < 32) ? ID_BITS : 32;
	localparam int CW    = $clog2(MAX_ENTRIES + 1);
	localparam int PW    = $clog2(MAX_ENTRIES);

	oidl_pkg::req_t         req_s1;
	logic                   vld_s1;
	logic [2:0]             cmd_s2;
	logic [7:0]             pos_s2;
	logic [KEY_W-1:0]       key_s2;
	logic                   zero_s2;
	logic [MAX_ENTRIES-1:0] match_s2;
	logic                   vld_s2;

	logic [CW-1:0]          count_q;
	logic [PW-1:0]          active_q;
	logic [2:0]             status_q;
	logic                   rsp_valid_q;

	logic [KEY_W-1:0]       key_s1;
	logic                   exec_fire;
	logic [MAX_ENTRIES-1:0] cell_match;
	logic [KEY_W-1:0]       vals [MAX_ENTRIES];

	logic [2:0]             status_nxt;
	logic [CW-1:0]          count_nxt;
	logic [PW-1:0]          active_nxt;
	oidl_pkg::cell_op_t [MAX_ENTRIES-1:0] ops;

	assign key_s1    = req_s1.pane_id[KEY_W-1:0];
	assign exec_fire = vld_s2 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !vld_s1 && (!vld_s2 || exec_fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			count_q     <= '0;
			active_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			vld_s1 <= req_valid && req_ready;
			if (vld_s1)
				vld_s2 <= 1'b1;
			else if (exec_fire)
				vld_s2 <= 1'b0;
			if (exec_fire) begin
				count_q     <= count_nxt;
				active_q    <= active_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			req_s1 <= req;
		if (vld_s1) begin
			cmd_s2  <= req_s1.command;
			pos_s2  <= req_s1.position;
			key_s2  <= key_s1;
			zero_s2 <= (key_s1 == '0);
			for (int i = 0; i < MAX_ENTRIES; i++)
				match_s2[i] <= cell_match[i] && (CW'(i) < count_q);
		end
		if (exec_fire)
			status_q <= status_nxt;
	end

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		logic [KEY_W-1:0] left_val;
		logic [KEY_W-1:0] right_val;

		if (g == 0) begin : g_first
			assign left_val = key_s2;
		end else begin : g_mid_l
			assign left_val = vals[g-1];
		end
		if (g == MAX_ENTRIES - 1) begin : g_last
			assign right_val = vals[g];
		end else begin : g_mid_r
			assign right_val = vals[g+1];
		end

		oidl_cell #(
			.KEY_W(KEY_W)
		) u_cell (
			.clk      (clk),
			.en       (exec_fire),
			.op       (ops[g]),
			.cmp_key  (key_s1),
			.load_key (key_s2),
			.left_val (left_val),
			.right_val(right_val),
			.value    (vals[g]),
			.match    (cell_match[g])
		);
	end

	oidl_exec #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.CW         (CW),
		.PW         (PW)
	) u_exec (
		.command   (cmd_s2),
		.position  (pos_s2),
		.key_zero  (zero_s2),
		.match     (match_s2),
		.count     (count_q),
		.active    (active_q),
		.status    (status_nxt),
		.count_nxt (count_nxt),
		.active_nxt(active_nxt),
		.ops       (ops)
	);

	assign rsp_valid = rsp_valid_q;

	always_comb begin
		rsp.status       = status_q;
		rsp.active_index = 4'(active_q);
		rsp.active_id    = (count_q == '0) ? 32'd0 : 32'(vals[active_q]);
		rsp.entry_count  = 5'(count_q);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above capacity");

	a_cursor_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) ? (active_q == '0) : (CW'(active_q) < count_q))
		else $error("cursor outside the list");

	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $onehot0(match_s2))
		else $error("ID held in more than one slot");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_s1 && vld_s2 && !exec_fire) || !req_ready)
		else $error("request accepted while both stages are busy");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && status_nxt != oidl_pkg::ST_OK |=> $stable(count_q))
		else $error("rejected request changed the list");

endmodule
